// ===== hw/rtl/dbsf_pkg.sv =====
`timescale 1ns / 1ps

package dbsf_pkg;

  // default sizes
  localparam int NUM_BINS_DEF       = 1024;
  localparam int QUERY_POS_BITS_DEF = 16;

  // fixed field widths
  localparam int REF_POS_BITS  = 32;
  localparam int SEED_LEN_BITS = 5;
  localparam int BIN_W_BITS    = 16;
  localparam int THRESH_BITS   = 16;
  localparam int NUM_BINS_BITS = 11;
  localparam int COUNT_BITS    = 18;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  // register reset values
  localparam logic [SEED_LEN_BITS-1:0] SEED_LEN_RST  = 5'd4;
  localparam logic [BIN_W_BITS-1:0]    BIN_WIDTH_RST = 16'd12;
  localparam logic [THRESH_BITS-1:0]   THRESH_RST    = 16'd8;
  localparam logic [NUM_BINS_BITS-1:0] NUM_BINS_RST  = 11'd1024;

  // register index within the config space
  typedef enum logic [1:0] {
    REG_SEED_LENGTH = 2'd0,
    REG_BIN_WIDTH   = 2'd1,
    REG_THRESHOLD   = 2'd2,
    REG_NUM_BINS    = 2'd3
  } reg_idx_e;

  // item opcodes
  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_HIT   = 1'b1
  } op_e;

  // configuration bundle
  typedef struct packed {
    logic [SEED_LEN_BITS-1:0] seed_length;
    logic [BIN_W_BITS-1:0]    bin_width;
    logic [THRESH_BITS-1:0]   threshold;
    logic [NUM_BINS_BITS-1:0] num_bins;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_write;
    logic lim_calc;
    logic div_init;
    logic div_step;
    logic mem_read;
    logic mem_update;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_clear;
    logic in_below;
    logic over_limit;
    logic clr_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/dbsf_ctrl.sv =====
`timescale 1ns / 1ps

module dbsf_ctrl #(
  parameter int NUM_BINS = dbsf_pkg::NUM_BINS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dbsf_pkg::dp_sts_t sts_i,
  output dbsf_pkg::dp_cmd_t cmd_o,
  output logic              busy_o
);

  localparam int BIN_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_BITS = $clog2(BIN_BITS + 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLEAR  = 7'b0000010,
    S_LIMIT  = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_READ   = 7'b0100000,
    S_UPDATE = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_clear) begin
            state_d = S_CLEAR;
          end else if (!sts_i.in_below) begin
            state_d = S_LIMIT;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_write = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_LIMIT: begin
        cmd_o.lim_calc = 1'b1;
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CNT_BITS'(BIN_BITS - 1);
        state_d        = sts_i.over_limit ? S_READ : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_READ;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.mem_update = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers, reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // a clear item always starts the sweep
  a_clear_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i && sts_i.in_clear) |=> (state_q == S_CLEAR))
    else $error("clear item did not start the sweep");

  // division runs until its bit counter is exhausted
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && cnt_q != '0) |=> (state_q == S_DIV))
    else $error("division left early");

endmodule

// ===== hw/rtl/dbsf_datapath.sv =====
`timescale 1ns / 1ps

module dbsf_datapath #(
  parameter int NUM_BINS       = dbsf_pkg::NUM_BINS_DEF,
  parameter int QUERY_POS_BITS = dbsf_pkg::QUERY_POS_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dbsf_pkg::cfg_t                     cfg_i,
  input  dbsf_pkg::dp_cmd_t                  cmd_i,
  output dbsf_pkg::dp_sts_t                  sts_o,
  input  logic                               op_i,
  input  logic [dbsf_pkg::REF_POS_BITS-1:0]  ref_pos_i,
  input  logic [QUERY_POS_BITS-1:0]          query_pos_i,
  output logic                               cand_valid_o,
  output logic [dbsf_pkg::REF_POS_BITS-1:0]  cand_ref_pos_o,
  output logic [QUERY_POS_BITS-1:0]          cand_query_pos_o
);

  localparam int RPW      = dbsf_pkg::REF_POS_BITS;
  localparam int CW       = dbsf_pkg::COUNT_BITS;
  localparam int KW       = dbsf_pkg::SEED_LEN_BITS;
  localparam int BIN_BITS = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int LIM_BITS = BIN_BITS + dbsf_pkg::BIN_W_BITS;
  localparam int NB_W     = (BIN_BITS + 1 > dbsf_pkg::NUM_BINS_BITS) ?
                            BIN_BITS + 1 : dbsf_pkg::NUM_BINS_BITS;
  localparam int OVW      = QUERY_POS_BITS + KW + 1;
  localparam int ENTRY_W  = 1 + QUERY_POS_BITS + CW;

  logic [RPW-1:0]            ref_q;
  logic [QUERY_POS_BITS-1:0] qpos_q;
  logic [RPW-1:0]            diff_q;
  logic [LIM_BITS-1:0]       lim_q;
  logic [LIM_BITS-1:0]       rem_q;
  logic [LIM_BITS-1:0]       dvs_q;
  logic [BIN_BITS-1:0]       bin_q;
  logic [BIN_BITS-1:0]       clr_addr_q;
  logic [ENTRY_W-1:0]        rd_q;
  logic                      cand_valid_q;
  logic [RPW-1:0]            cand_ref_q;
  logic [QUERY_POS_BITS-1:0] cand_qpos_q;
  logic [ENTRY_W-1:0]        mem [NUM_BINS];

  // effective bin count and width
  logic [NB_W-1:0]                     nb_raw, nb_eff;
  logic [BIN_BITS-1:0]                 nbm1;
  logic [dbsf_pkg::BIN_W_BITS-1:0]     w_eff;

  always_comb begin
    nb_raw = NB_W'(cfg_i.num_bins);
    nb_eff = nb_raw;
    if (nb_raw == '0) begin
      nb_eff = NB_W'(1);
    end else if (nb_raw > NB_W'(NUM_BINS)) begin
      nb_eff = NB_W'(NUM_BINS);
    end
    nbm1  = BIN_BITS'(nb_eff - NB_W'(1));
    w_eff = (cfg_i.bin_width == '0) ? dbsf_pkg::BIN_W_BITS'(1) : cfg_i.bin_width;
  end

  // status to controller
  logic div_ge;
  logic clr_done;

  assign clr_done         = (clr_addr_q == BIN_BITS'(NUM_BINS - 1));
  assign div_ge           = (rem_q >= dvs_q);
  assign sts_o.in_clear   = (op_i == dbsf_pkg::OP_CLEAR);
  assign sts_o.in_below   = (ref_pos_i < RPW'(query_pos_i));
  assign sts_o.over_limit = (diff_q >= RPW'(lim_q));
  assign sts_o.clr_done   = clr_done;

  // entry fields and count update
  logic                      rd_valid;
  logic [QUERY_POS_BITS-1:0] rd_last;
  logic [CW-1:0]             rd_cnt;
  logic [OVW-1:0]            sum_lk, ov_t;
  logic [KW-1:0]             ov, incr;
  logic [CW:0]               newc_w;
  logic [CW-1:0]             newc;
  logic [CW-1:0]             thr;
  logic                      cand_hit;

  always_comb begin
    rd_valid = rd_q[ENTRY_W-1];
    rd_last  = rd_q[CW +: QUERY_POS_BITS];
    rd_cnt   = rd_q[CW-1:0];
    sum_lk   = OVW'(rd_last) + OVW'(cfg_i.seed_length);
    ov_t     = sum_lk - OVW'(qpos_q);
    if (!rd_valid || sum_lk <= OVW'(qpos_q)) begin
      ov = '0;
    end else if (ov_t > OVW'(cfg_i.seed_length)) begin
      ov = cfg_i.seed_length;
    end else begin
      ov = ov_t[KW-1:0];
    end
    incr     = cfg_i.seed_length - ov;
    newc_w   = (CW + 1)'(rd_cnt) + (CW + 1)'(incr);
    newc     = newc_w[CW] ? '1 : newc_w[CW-1:0];
    thr      = CW'(cfg_i.threshold);
    cand_hit = (rd_cnt < thr) && (newc >= thr);
  end

  // hit registers and bin division
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ref_q  <= ref_pos_i;
      qpos_q <= query_pos_i;
      diff_q <= ref_pos_i - RPW'(query_pos_i);
    end
    if (cmd_i.lim_calc) begin
      lim_q <= LIM_BITS'(nbm1) * LIM_BITS'(w_eff);
    end
    if (cmd_i.div_init) begin
      rem_q <= LIM_BITS'(diff_q);
      dvs_q <= LIM_BITS'(w_eff) << (BIN_BITS - 1);
      bin_q <= sts_o.over_limit ? nbm1 : '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      bin_q <= (bin_q << 1) | BIN_BITS'(div_ge);
    end
  end

  // bin memory, sweep clear or read-modify-write
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_write) begin
      mem[clr_addr_q] <= '0;
    end else if (cmd_i.mem_update) begin
      mem[bin_q] <= {1'b1, qpos_q, newc};
    end
    if (cmd_i.mem_read) begin
      rd_q <= mem[bin_q];
    end
  end

  // sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_addr_q <= clr_done ? '0 : clr_addr_q + 1'b1;
    end
  end

  // candidate output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_valid_q <= 1'b0;
    end else begin
      cand_valid_q <= cmd_i.mem_update && cand_hit;
    end
  end

  // candidate payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_update && cand_hit) begin
      cand_ref_q  <= ref_q;
      cand_qpos_q <= qpos_q;
    end
  end

  assign cand_valid_o     = cand_valid_q;
  assign cand_ref_pos_o   = cand_ref_q;
  assign cand_query_pos_o = cand_qpos_q;

  // a candidate only follows a bin update
  a_cand_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_valid_q |-> $past(cmd_i.mem_update))
    else $error("candidate without bin update");

  // sweep returns to the first bin when done
  a_clr_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clr_write && clr_done) |=> (clr_addr_q == '0))
    else $error("sweep address did not wrap");

endmodule

// ===== hw/rtl/diagonal_band_seed_filter.sv =====
`timescale 1ns / 1ps
// hit item: busy through the limit, check, one-bit-per-cycle bin division, read and update
//   (division skipped if the bin clamps to the last one); candidate strobe the cycle after
// below-diagonal hit: busy stays low, next item may follow at once; no result
// clear item: busy while every bin memory entry is cleared, one entry written per cycle
// reset: async active low, then a clearing pass with busy high
// results are one-cycle strobes; the receiver cannot stall
module diagonal_band_seed_filter #(
  parameter int NUM_BINS       = dbsf_pkg::NUM_BINS_DEF,
  parameter int QUERY_POS_BITS = dbsf_pkg::QUERY_POS_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic [dbsf_pkg::REF_POS_BITS-1:0]   ref_pos_i,
  input  logic [QUERY_POS_BITS-1:0]           query_pos_i,
  // results
  output logic                                cand_valid_o,
  output logic [dbsf_pkg::REF_POS_BITS-1:0]   cand_ref_pos_o,
  output logic [QUERY_POS_BITS-1:0]           cand_query_pos_o,
  // config port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dbsf_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [dbsf_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [dbsf_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);

  localparam int DW = dbsf_pkg::CFG_DATA_BITS;

  dbsf_pkg::cfg_t     cfg_q;
  dbsf_pkg::reg_idx_e reg_idx;
  dbsf_pkg::dp_cmd_t  cmd;
  dbsf_pkg::dp_sts_t  sts;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dbsf_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed_length <= dbsf_pkg::SEED_LEN_RST;
      cfg_q.bin_width   <= dbsf_pkg::BIN_WIDTH_RST;
      cfg_q.threshold   <= dbsf_pkg::THRESH_RST;
      cfg_q.num_bins    <= dbsf_pkg::NUM_BINS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        dbsf_pkg::REG_SEED_LENGTH: begin
          cfg_q.seed_length <= pwdata[dbsf_pkg::SEED_LEN_BITS-1:0];
        end
        dbsf_pkg::REG_BIN_WIDTH: begin
          cfg_q.bin_width <= pwdata[dbsf_pkg::BIN_W_BITS-1:0];
        end
        dbsf_pkg::REG_THRESHOLD: begin
          cfg_q.threshold <= pwdata[dbsf_pkg::THRESH_BITS-1:0];
        end
        dbsf_pkg::REG_NUM_BINS: begin
          cfg_q.num_bins <= pwdata[dbsf_pkg::NUM_BINS_BITS-1:0];
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // config readback
  always_comb begin
    case (reg_idx)
      dbsf_pkg::REG_SEED_LENGTH: prdata = DW'(cfg_q.seed_length);
      dbsf_pkg::REG_BIN_WIDTH:   prdata = DW'(cfg_q.bin_width);
      dbsf_pkg::REG_THRESHOLD:   prdata = DW'(cfg_q.threshold);
      dbsf_pkg::REG_NUM_BINS:    prdata = DW'(cfg_q.num_bins);
      default:                   prdata = '0;
    endcase
  end

  // controller
  dbsf_ctrl #(
    .NUM_BINS (NUM_BINS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath
  dbsf_datapath #(
    .NUM_BINS       (NUM_BINS),
    .QUERY_POS_BITS (QUERY_POS_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .op_i             (op_i),
    .ref_pos_i        (ref_pos_i),
    .query_pos_i      (query_pos_i),
    .cand_valid_o     (cand_valid_o),
    .cand_ref_pos_o   (cand_ref_pos_o),
    .cand_query_pos_o (cand_query_pos_o)
  );

endmodule
